FILE: hdl/hec_pkg.sv
package hec_pkg;

  localparam int MAX_CODE_BITS = 31;
  localparam int WORD_W        = 31;
  localparam int CFG_W         = 5;
  localparam int PAR_W         = $clog2(WORD_W + 1);
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [CFG_W-1:0] DATA_BITS_RST = CFG_W'(4);

  typedef enum logic {
    REG_DATA_BITS = 1'b0,
    REG_NONE      = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [WORD_W-1:0] word_in;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic              check_failed;
  } out_word_t;

  function automatic int parity_count(input int d);
    int r;
    r = 1;
    while ((1 << r) <= d + r) r++;
    return r;
  endfunction

  function automatic int max_data_bits();
    int best;
    best = 1;
    for (int d = 1; d < (1 << CFG_W); d++) begin
      if (d + parity_count(d) <= MAX_CODE_BITS) best = d;
    end
    return best;
  endfunction

  localparam int DATA_W = max_data_bits();

  localparam logic [CFG_W-1:0] DATA_BITS_MAX = CFG_W'(DATA_W);

  // data bits in ascending non power-of-two positions, parity slots left clear
  function automatic logic [WORD_W-1:0] place_data(input logic [DATA_W-1:0] data);
    logic [WORD_W-1:0] w;
    int                idx;
    w   = '0;
    idx = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (idx < DATA_W) w[p-1] = data[idx];
        idx++;
      end
    end
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pull_data(input logic [WORD_W-1:0] w);
    logic [DATA_W-1:0] data;
    int                idx;
    data = '0;
    idx  = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (idx < DATA_W) data[idx] = w[p-1];
        idx++;
      end
    end
    return data;
  endfunction

  function automatic logic [WORD_W-1:0] cover_mask(input int k);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      if (((p & (p - 1)) != 0) && (((p >> k) & 1) != 0)) m[p-1] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] data_mask(input logic [CFG_W-1:0] d);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W; i++) begin
      m[i] = (CFG_W'(i) < d);
    end
    return m;
  endfunction

  // fill parity slots of a word that already holds its data bits
  function automatic logic [WORD_W-1:0] add_parity(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] c;
    c = w;
    for (int k = 0; k < PAR_W; k++) begin
      if ((1 << k) <= WORD_W) c[(1 << k) - 1] = ^(w & cover_mask(k));
    end
    return c;
  endfunction

endpackage

FILE: hdl/hec_pipe.sv
module hec_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hec_pkg::CFG_W-1:0]     data_bits,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hec_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hec_pkg::out_word_t            out_data
);

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic rdy1, rdy2, rdy3;

  hec_pkg::cmd_t                  cmd1_r, cmd2_r;
  logic [hec_pkg::WORD_W-1:0]     word1_r, word2_r;
  logic [hec_pkg::DATA_W-1:0]     data1_r, data2_r;
  logic [hec_pkg::WORD_W-1:0]     code2_r;
  hec_pkg::out_word_t             res3_r;

  logic [hec_pkg::DATA_W-1:0]     data1_nxt;
  logic [hec_pkg::WORD_W-1:0]     code2_nxt;
  hec_pkg::out_word_t             res3_nxt;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;

  always_comb begin
    if (in_data.command == hec_pkg::CMD_ENCODE) begin
      data1_nxt = in_data.word_in[hec_pkg::DATA_W-1:0] & hec_pkg::data_mask(data_bits);
    end else begin
      data1_nxt = hec_pkg::pull_data(in_data.word_in) & hec_pkg::data_mask(data_bits);
    end
  end

  assign code2_nxt = hec_pkg::add_parity(hec_pkg::place_data(data1_r));

  always_comb begin
    res3_nxt.word_out     = code2_r;
    res3_nxt.check_failed = 1'b0;
    if (cmd2_r == hec_pkg::CMD_CHECK) begin
      if (code2_r == word2_r) begin
        res3_nxt.word_out = hec_pkg::WORD_W'(data2_r);
      end else begin
        res3_nxt.word_out     = '0;
        res3_nxt.check_failed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1_r  <= in_data.command;
      word1_r <= in_data.word_in;
      data1_r <= data1_nxt;
    end
    if (rdy2) begin
      cmd2_r  <= cmd1_r;
      word2_r <= word1_r;
      data2_r <= data1_r;
      code2_r <= code2_nxt;
    end
    if (rdy3) begin
      res3_r <= res3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = res3_r;

endmodule

FILE: hdl/hamming_encode_check.sv
// Hamming encoder and codeword checker for 1 to 26 data bits, set through the
// data_bits register (byte address 0, reset 4; pwdata[4:0] = 0 reads as 1,
// 27 to 31 as 26). Command 0 encodes the low data_bits bits of word_in into a
// codeword with position 1 at bit 0; command 1 checks a received codeword and
// returns its data bits, or zero with check_failed set when the word is not a
// valid codeword (errors are detected, not corrected). One word is taken every
// cycle while out_stall does not hold the pipeline; extraction and masking,
// parity trees, and the compare each own a register stage. Change data_bits
// only while no word is in flight.
module hamming_encode_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hec_pkg::APB_AW-1:0]    paddr,
  input  logic [hec_pkg::APB_DW-1:0]    pwdata,
  output logic [hec_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hec_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hec_pkg::out_word_t            out_data
);

  logic [hec_pkg::CFG_W-1:0] data_bits_r, data_bits_nxt;
  logic [hec_pkg::CFG_W-1:0] wr_val;
  hec_pkg::reg_idx_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = hec_pkg::reg_idx_t'(paddr[hec_pkg::APB_AW-1]);

  always_comb begin
    if (pwdata[hec_pkg::CFG_W-1:0] == '0) begin
      wr_val = hec_pkg::CFG_W'(1);
    end else if (pwdata[hec_pkg::CFG_W-1:0] > hec_pkg::DATA_BITS_MAX) begin
      wr_val = hec_pkg::DATA_BITS_MAX;
    end else begin
      wr_val = pwdata[hec_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    data_bits_nxt = data_bits_r;
    if (psel && penable && pwrite && pready && reg_sel == hec_pkg::REG_DATA_BITS) begin
      data_bits_nxt = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r <= hec_pkg::DATA_BITS_RST;
    end else begin
      data_bits_r <= data_bits_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == hec_pkg::REG_DATA_BITS) begin
      prdata = hec_pkg::APB_DW'(data_bits_r);
    end
  end

  hec_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_bits (data_bits_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: verif/hamming_encode_check_tb.sv
module hamming_encode_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class hamming_predictor;
    logic [hec_pkg::CFG_W-1:0] data_bits;
    hec_pkg::out_word_t        expected_words[$];
    int unsigned               mismatches;

    function new();
      data_bits   = hec_pkg::DATA_BITS_RST;
      mismatches  = 0;
    endfunction

    function int parity_bits(int d);
      int r;
      r = 1;
      while ((1 << r) <= d + r) r++;
      return r;
    endfunction

    function int code_len();
      return int'(data_bits) + parity_bits(int'(data_bits));
    endfunction

    function void write_reg(hec_pkg::reg_idx_t idx, logic [hec_pkg::APB_DW-1:0] value);
      int d;
      if (idx != hec_pkg::REG_DATA_BITS) return;
      d = int'(value[hec_pkg::CFG_W-1:0]);
      if (d == 0) d = 1;
      while (d > 1 && d + parity_bits(d) > hec_pkg::MAX_CODE_BITS) d--;
      data_bits = d[hec_pkg::CFG_W-1:0];
    endfunction

    function logic [hec_pkg::WORD_W-1:0] codeword(logic [hec_pkg::WORD_W-1:0] data);
      logic [hec_pkg::WORD_W-1:0] w;
      int                         syn;
      int                         idx;
      int                         n;
      int                         r;
      n   = code_len();
      r   = parity_bits(int'(data_bits));
      w   = '0;
      syn = 0;
      idx = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          if (idx < int'(data_bits) && data[idx]) begin
            w[p-1] = 1'b1;
            syn ^= p;
          end
          idx++;
        end
      end
      for (int k = 0; k < r; k++) begin
        if (syn[k]) w[(1 << k) - 1] = 1'b1;
      end
      return w;
    endfunction

    function logic [hec_pkg::WORD_W-1:0] data_of(logic [hec_pkg::WORD_W-1:0] w);
      logic [hec_pkg::WORD_W-1:0] data;
      int                         idx;
      int                         n;
      n    = code_len();
      data = '0;
      idx  = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          if (idx < int'(data_bits) && w[p-1]) data[idx] = 1'b1;
          idx++;
        end
      end
      return data;
    endfunction

    function void note_word(hec_pkg::in_word_t item);
      hec_pkg::out_word_t         want;
      logic [hec_pkg::WORD_W-1:0] data;
      logic [hec_pkg::WORD_W-1:0] keep;
      want = '0;
      if (item.command == hec_pkg::CMD_ENCODE) begin
        keep          = (hec_pkg::WORD_W'(1) << data_bits) - hec_pkg::WORD_W'(1);
        want.word_out = codeword(item.word_in & keep);
      end else begin
        data = data_of(item.word_in);
        if (codeword(data) == item.word_in) begin
          want.word_out = data;
        end else begin
          want.check_failed = 1'b1;
        end
      end
      expected_words = {expected_words, want};
    endfunction

    function void check_word(hec_pkg::out_word_t got);
      hec_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word %h with nothing expected", got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.word_out !== want.word_out) begin
        $error("word_out: expected %h, got %h", want.word_out, got.word_out);
        mismatches++;
      end
      if (got.check_failed !== want.check_failed) begin
        $error("check_failed: expected %b, got %b", want.check_failed, got.check_failed);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [hec_pkg::APB_AW-1:0] paddr     = '0;
  logic [hec_pkg::APB_DW-1:0] pwdata    = '0;
  logic [hec_pkg::APB_DW-1:0] prdata;
  logic                       pready;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  hec_pkg::in_word_t          in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  hec_pkg::out_word_t         out_data;

  hamming_predictor board;
  bit               no_idle  = 1'b0;
  bit               hold_req = 1'b0;
  int               hold_left;

  always #1 clk = ~clk;

  hamming_encode_check u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  task automatic send_word(hec_pkg::in_word_t item);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 6) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(item);
  endtask

  task automatic send_cmd(hec_pkg::cmd_t cmd, logic [hec_pkg::WORD_W-1:0] w);
    hec_pkg::in_word_t item;
    item.command = cmd;
    item.word_in = w;
    send_word(item);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(hec_pkg::reg_idx_t idx, logic [hec_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, value);
  endtask

  // mostly valid codewords and plain encodes, with some damaged and junk words
  function automatic hec_pkg::in_word_t random_word();
    hec_pkg::in_word_t          item;
    logic [hec_pkg::WORD_W-1:0] raw;
    logic [hec_pkg::WORD_W-1:0] keep;
    int                         n;
    int                         pick;
    n    = board.code_len();
    raw  = hec_pkg::WORD_W'($urandom);
    keep = (hec_pkg::WORD_W'(1) << board.data_bits) - hec_pkg::WORD_W'(1);
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) raw = $urandom_range(1) ? '1 : '0;
    item.command = hec_pkg::CMD_CHECK;
    if (pick < 30) begin
      item.command = hec_pkg::CMD_ENCODE;
      item.word_in = raw;
    end else if (pick < 40) begin
      item.command = hec_pkg::CMD_ENCODE;
      item.word_in = raw & keep;
    end else if (pick < 80) begin
      item.word_in = board.codeword(raw & keep);
    end else if (pick < 90) begin
      item.word_in = board.codeword(raw & keep) ^
                     (hec_pkg::WORD_W'(1) << $urandom_range(n - 1));
    end else if (pick < 95 && n < hec_pkg::WORD_W) begin
      item.word_in = board.codeword(raw & keep) |
                     (hec_pkg::WORD_W'(1) << $urandom_range(hec_pkg::WORD_W - 1, n));
    end else begin
      item.word_in = raw;
    end
    return item;
  endfunction

  initial begin
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_word(out_data);
      if (hold_req) begin
        hold_left = 200;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 6);
      end
    end
  end

  initial begin
    int widths[15];
    int width;
    widths = '{26, 0, 31, 27, 1, 2, 3, 7, 11, 12, 19, 25, 5, 4, 0};
    board  = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width: four data bits, seven-bit codeword
    send_cmd(hec_pkg::CMD_ENCODE, '0);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h0000000F);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h7FFFFFFF);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h7FFFFFF0);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h00000001);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h00000008);
    send_cmd(hec_pkg::CMD_CHECK, '0);
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'hF));
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'h5) ^ 31'h1);
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'h9) ^ 31'h40);
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'h3) | 31'h80);
    send_cmd(hec_pkg::CMD_CHECK, 31'h7FFFFFFF);
    send_cmd(hec_pkg::CMD_CHECK, 31'h40000000);
    drain();

    // write to the unused register must leave the width alone
    cfg_write(hec_pkg::REG_NONE, 32'hFFFFFFFF);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h5);
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'h5));
    drain();

    cfg_write(hec_pkg::REG_DATA_BITS, 32'd26);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h03FFFFFF);
    send_cmd(hec_pkg::CMD_ENCODE, 31'h7FFFFFFF);
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'h03FFFFFF));
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'h03FFFFFF) ^ 31'h40000000);
    send_cmd(hec_pkg::CMD_CHECK, board.codeword(31'h02AAAAAA));
    drain();

    for (int ph = 0; ph < 15; ph++) begin
      width = (ph == 14) ? $urandom_range(31) : widths[ph];
      cfg_write(hec_pkg::REG_DATA_BITS, ($urandom & ~32'h1F) | hec_pkg::APB_DW'(width));
      no_idle = (ph == 5);
      if (ph == 2) begin
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (60) send_word(random_word());
        no_idle = 1'b0;
        drain();
      end
      repeat (125) send_word(random_word());
      drain();
    end
    no_idle = 1'b0;
    repeat (10) @(posedge clk);

    if (board.mismatches == 0 && board.expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
